// ===== rtl/chacha_pkg.sv =====
`default_nettype none
package chacha_pkg;
	localparam int DOUBLE_ROUNDS_DEF = 10;
	localparam int NUM_REGS = 7;
	localparam int ADDR_W = 6;

	localparam logic [2:0] REG_KEY01 = 3'd0;
	localparam logic [2:0] REG_KEY23 = 3'd1;
	localparam logic [2:0] REG_KEY45 = 3'd2;
	localparam logic [2:0] REG_KEY67 = 3'd3;
	localparam logic [2:0] REG_NONCE01 = 3'd4;
	localparam logic [2:0] REG_NONCE2 = 3'd5;
	localparam logic [2:0] REG_COUNTER = 3'd6;

	localparam logic [31:0] SIGMA0 = 32'h61707865;
	localparam logic [31:0] SIGMA1 = 32'h3320646e;
	localparam logic [31:0] SIGMA2 = 32'h79622d32;
	localparam logic [31:0] SIGMA3 = 32'h6b206574;

	typedef logic [15:0][31:0] state_t;

	typedef struct packed {
		logic [7:0] data;
		logic       eom;
	} item_t;

	typedef enum logic [1:0] {
		GEN_IDLE,
		GEN_ROUND,
		GEN_ADD,
		GEN_FULL
	} gen_state_t;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
		logic [63:0] t;
		t = {v, v} << s;
		return t[63:32];
	endfunction

	function automatic logic [127:0] quarter(input logic [31:0] a, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d);
		logic [31:0] aa, bb, cc, dd;
		aa = a + b; dd = rotl(d ^ aa, 16);
		cc = c + dd; bb = rotl(b ^ cc, 12);
		aa = aa + bb; dd = rotl(dd ^ aa, 8);
		cc = cc + dd; bb = rotl(bb ^ cc, 7);
		return {aa, bb, cc, dd};
	endfunction
endpackage
`default_nettype wire

// ===== rtl/chacha_fifo.sv =====
`default_nettype none
module chacha_fifo import chacha_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  wr_en,
	input  wire item_t wr_data,
	output logic       full,
	input  wire logic  rd_en,
	output item_t      rd_data,
	output logic       empty
);
	item_t mem_q [4];
	logic [2:0] wptr_q, rptr_q;

	assign full = (wptr_q[1:0] == rptr_q[1:0]) && (wptr_q[2] != rptr_q[2]);
	assign empty = wptr_q == rptr_q;
	assign rd_data = mem_q[rptr_q[1:0]];

	always_ff @(posedge clk) begin
		if (wr_en && !full) begin
			mem_q[wptr_q[1:0]] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
		end else begin
			if (wr_en && !full) wptr_q <= wptr_q + 3'd1;
			if (rd_en && !empty) rptr_q <= rptr_q + 3'd1;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/chacha_core.sv =====
`default_nettype none
module chacha_core import chacha_pkg::*; #(
	parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   reload,
	input  wire state_t init_state,
	output logic [31:0] ctr_lo,
	output logic [31:0] ctr_hi,
	input  wire logic   take,
	output logic        ready,
	output state_t      block
);
	localparam int RW = $clog2(2 * DOUBLE_ROUNDS + 1);

	gen_state_t state_q, state_d;
	state_t x_q, init_q, block_q;
	logic [RW-1:0] round_q;
	logic [31:0] lo_q, hi_q;
	state_t rnd;
	state_t seed;

	always_comb begin
		seed = init_state;
		seed[12] = lo_q;
		seed[13] = hi_q;
	end

	always_comb begin
		rnd = x_q;
		if (!round_q[0]) begin
			{rnd[0], rnd[4], rnd[8], rnd[12]} = quarter(x_q[0], x_q[4], x_q[8], x_q[12]);
			{rnd[1], rnd[5], rnd[9], rnd[13]} = quarter(x_q[1], x_q[5], x_q[9], x_q[13]);
			{rnd[2], rnd[6], rnd[10], rnd[14]} = quarter(x_q[2], x_q[6], x_q[10], x_q[14]);
			{rnd[3], rnd[7], rnd[11], rnd[15]} = quarter(x_q[3], x_q[7], x_q[11], x_q[15]);
		end else begin
			{rnd[0], rnd[5], rnd[10], rnd[15]} = quarter(x_q[0], x_q[5], x_q[10], x_q[15]);
			{rnd[1], rnd[6], rnd[11], rnd[12]} = quarter(x_q[1], x_q[6], x_q[11], x_q[12]);
			{rnd[2], rnd[7], rnd[8], rnd[13]} = quarter(x_q[2], x_q[7], x_q[8], x_q[13]);
			{rnd[3], rnd[4], rnd[9], rnd[14]} = quarter(x_q[3], x_q[4], x_q[9], x_q[14]);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			GEN_IDLE: state_d = GEN_ROUND;
			GEN_ROUND: if (round_q == RW'(2 * DOUBLE_ROUNDS - 1)) state_d = GEN_ADD;
			GEN_ADD: state_d = GEN_FULL;
			GEN_FULL: if (take) state_d = GEN_IDLE;
			default: state_d = GEN_IDLE;
		endcase
		if (reload) state_d = GEN_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= GEN_IDLE;
			round_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == GEN_ROUND) round_q <= round_q + RW'(1);
			else round_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (reload) begin
			lo_q <= init_state[12];
			hi_q <= init_state[13];
		end else if (state_q == GEN_ADD) begin
			lo_q <= lo_q + 32'd1;
			if (lo_q == 32'hffffffff) hi_q <= hi_q + 32'd1;
		end
		unique case (state_q)
			GEN_IDLE: begin
				x_q <= seed;
				init_q <= seed;
			end
			GEN_ROUND: x_q <= rnd;
			GEN_ADD: for (int i = 0; i < 16; i++) block_q[i] <= x_q[i] + init_q[i];
			default: ;
		endcase
	end

	assign ready = state_q == GEN_FULL;
	assign block = block_q;
	assign ctr_lo = lo_q;
	assign ctr_hi = hi_q;

`ifndef SYNTHESIS
	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == GEN_ROUND |-> round_q < RW'(2 * DOUBLE_ROUNDS)) else $error("round overrun");
	a_add_follows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == GEN_ADD && !reload |=> state_q == GEN_FULL) else $error("add lost");
	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == GEN_FULL && !take && !reload |=> state_q == GEN_FULL) else $error("block lost");
`endif
endmodule
`default_nettype wire

// ===== rtl/chacha20_keystream_xor.sv =====
`default_nettype none
// Byte-wide ChaCha20 XOR with an APB register port (64-bit data, key at 0x00-0x18,
// nonce at 0x20 and 0x28, initial counter at 0x30). Bytes enter a four-deep input
// queue; each is combined with the next keystream byte and placed in a four-deep
// result queue. A keystream block is built in steps (load, one round per cycle,
// add) and is computed while the previous one is in use; no byte is combined while
// a block is handed over. After reset or after a register write, bytes wait until
// the first block is ready. A register write restarts the counter and discards the
// current block.
module chacha20_keystream_xor import chacha_pkg::*; #(
	parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [63:0]       pwdata,
	output logic [63:0]            prdata,
	output logic                   pready,
	input  wire logic [7:0]        data_in,
	input  wire logic              end_of_message,
	input  wire logic              push,
	output logic                   full,
	output logic [7:0]             data_out,
	output logic                   end_of_message_out,
	output logic                   empty,
	input  wire logic              pop
);
	logic [63:0] key01_q, key23_q, key45_q, key67_q, nonce01_q, ctr_q;
	logic [31:0] nonce2_q;
	logic wr, reload, reload_q;
	logic [2:0] ridx;
	state_t init_state, blk_q, core_blk;
	logic [5:0] pos_q;
	logic blk_valid_q, core_ready, take, fire;
	logic [31:0] ctr_lo, ctr_hi, word;
	item_t in_item, fi_item, out_item;
	logic fi_empty, fo_full;

	assign pready = 1'b1;
	assign ridx = paddr[5:3];
	assign wr = psel && penable && pwrite;
	assign reload = wr && ridx != 3'd7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key01_q <= '0; key23_q <= '0; key45_q <= '0; key67_q <= '0;
			nonce01_q <= '0; nonce2_q <= '0; ctr_q <= '0;
		end else if (wr) begin
			unique case (ridx)
				REG_KEY01: key01_q <= pwdata;
				REG_KEY23: key23_q <= pwdata;
				REG_KEY45: key45_q <= pwdata;
				REG_KEY67: key67_q <= pwdata;
				REG_NONCE01: nonce01_q <= pwdata;
				REG_NONCE2: nonce2_q <= pwdata[31:0];
				REG_COUNTER: ctr_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_KEY01: prdata = key01_q;
			REG_KEY23: prdata = key23_q;
			REG_KEY45: prdata = key45_q;
			REG_KEY67: prdata = key67_q;
			REG_NONCE01: prdata = nonce01_q;
			REG_NONCE2: prdata = {32'd0, nonce2_q};
			REG_COUNTER: prdata = ctr_q;
			default: prdata = '0;
		endcase
	end

	// Counter words here are the values loaded on reload; the core tracks them after.
	always_comb begin
		init_state = {nonce2_q, nonce01_q[63:32], nonce01_q[31:0] + ctr_q[63:32],
			ctr_q[31:0], key67_q, key45_q, key23_q, key01_q, SIGMA3, SIGMA2, SIGMA1,
			SIGMA0};
	end

	assign in_item = '{data: data_in, eom: end_of_message};

	chacha_fifo u_in (
		.clk, .arst_n, .wr_en(push), .wr_data(in_item), .full,
		.rd_en(fire), .rd_data(fi_item), .empty(fi_empty)
	);

	// The core loads its counter from init_state on reload, which happens at reset
	// via a one-shot below.
	logic boot_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) boot_q <= 1'b1;
		else boot_q <= 1'b0;
	end

	// The registers take a write at the same edge, so the counter is loaded again
	// in the following cycle from the new values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) reload_q <= 1'b0;
		else reload_q <= reload;
	end

	chacha_core #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_core (
		.clk, .arst_n, .reload(reload || reload_q || boot_q), .init_state, .ctr_lo,
		.ctr_hi, .take, .ready(core_ready), .block(core_blk)
	);

	assign take = core_ready && !blk_valid_q && !reload;
	assign fire = blk_valid_q && !fi_empty && !fo_full && !reload;
	assign word = blk_q[pos_q[5:2]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_valid_q <= 1'b0;
			pos_q <= '0;
		end else if (reload) begin
			blk_valid_q <= 1'b0;
			pos_q <= '0;
		end else if (take) begin
			blk_valid_q <= 1'b1;
			pos_q <= '0;
		end else if (fire) begin
			pos_q <= pos_q + 6'd1;
			if (pos_q == 6'd63) blk_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) blk_q <= core_blk;
	end

	assign out_item = '{data: fi_item.data ^ word[{pos_q[1:0], 3'b000} +: 8],
		eom: fi_item.eom};

	chacha_fifo u_out (
		.clk, .arst_n, .wr_en(fire), .wr_data(out_item), .full(fo_full),
		.rd_en(pop), .rd_data({data_out, end_of_message_out}), .empty
	);

`ifndef SYNTHESIS
	a_fire_needs_block: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> blk_valid_q) else $error("transfer without keystream");
	a_take_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> !fire) else $error("block replaced while in use");
	a_reload_empties: assert property (@(posedge clk) disable iff (!arst_n)
		reload |=> !blk_valid_q) else $error("stale block after reload");
	a_ctr_reloaded: assert property (@(posedge clk) disable iff (!arst_n)
		reload_q |=> ctr_lo == ctr_q[31:0] && ctr_hi == nonce01_q[31:0] + ctr_q[63:32])
		else $error("counter not reloaded");
`endif
endmodule
`default_nettype wire
